### sv/tte_pkg.sv
package tte_pkg;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_HEADER = 3'd1,
		PH_TAG    = 3'd2,
		PH_LEN    = 3'd3,
		PH_SKIP   = 3'd4,
		PH_LENM   = 3'd5,
		PH_COPY   = 3'd6,
		PH_DRAIN  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		REG_WANTED_TAG     = 2'd0,
		REG_EXTENSION_CODE = 2'd1,
		REG_HEADER_LENGTH  = 2'd2,
		REG_OUTPUT_LIMIT   = 2'd3
	} reg_index_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	localparam logic [7:0] WantedTagReset     = 8'd0;
	localparam logic [7:0] ExtensionCodeReset = 8'd0;
	localparam logic [7:0] HeaderLengthReset  = 8'd16;
	localparam logic [7:0] OutputLimitReset   = 8'd255;

	localparam int unsigned ResDepth = 4;
	localparam int unsigned ResPtrW  = 2;
	localparam int unsigned ResCntW  = 3;

	localparam logic [7:0] MinExtLength = 8'd2;

	typedef struct packed {
		logic [7:0] wanted_tag;
		logic [7:0] extension_code;
		logic [7:0] header_length;
		logic [7:0] output_limit;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_value;
		logic [7:0] delivered_count;
		logic       found;
		logic       cut_short;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} res_pair_t;

endpackage

### sv/tte_parser.sv
module tte_parser
	import tte_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] packet_byte,
	input  logic       packet_end,
	input  cfg_t       cfg,
	output res_pair_t  res
);

	phase_t     phase_q;
	logic [7:0] header_left_q;
	logic [7:0] bytes_left_q;
	logic       ext_q;
	logic [7:0] copy_left_q;
	logic [7:0] copied_q;

	phase_t     phase_d;
	logic [7:0] header_left_d;
	logic [7:0] bytes_left_d;
	logic       ext_d;
	logic [7:0] copy_left_d;
	logic [7:0] copied_d;

	logic       ext_in;
	logic [7:0] bl_in;
	phase_t     tag_phase;
	logic [7:0] tag_bl;
	logic       tag_ext;
	logic       done;
	logic       matching;
	logic [7:0] capped;

	assign ext_in = (phase_q == PH_START) ? 1'b0 : ext_q;
	assign bl_in  = (phase_q == PH_START) ? 8'd0 : bytes_left_q;
	assign capped = (packet_byte < cfg.output_limit) ? packet_byte : cfg.output_limit;

	always_comb begin
		tag_phase = PH_LEN;
		tag_bl    = bl_in;
		tag_ext   = ext_in;
		if (ext_in) begin
			tag_bl = bl_in - 8'd1;
			if (packet_byte == cfg.wanted_tag) begin
				tag_phase = PH_LENM;
			end else begin
				tag_ext   = 1'b0;
				tag_phase = PH_SKIP;
			end
		end else if (packet_byte == cfg.wanted_tag) begin
			tag_phase = PH_LENM;
		end else begin
			if (packet_byte == cfg.extension_code) begin
				tag_ext = 1'b1;
			end
			tag_phase = PH_LEN;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		header_left_d = header_left_q;
		bytes_left_d  = bytes_left_q;
		ext_d         = ext_q;
		copy_left_d   = copy_left_q;
		copied_d      = copied_q;
		done          = 1'b0;
		matching      = 1'b0;
		res           = '0;
		unique case (phase_q)
			PH_START: begin
				ext_d        = 1'b0;
				bytes_left_d = 8'd0;
				copy_left_d  = 8'd0;
				copied_d     = 8'd0;
				if (cfg.header_length == 8'd0) begin
					phase_d      = tag_phase;
					bytes_left_d = tag_bl;
					ext_d        = tag_ext;
				end else begin
					header_left_d = cfg.header_length - 8'd1;
					phase_d       = (header_left_d != 8'd0) ? PH_HEADER : PH_TAG;
				end
			end
			PH_HEADER: begin
				header_left_d = header_left_q - 8'd1;
				if (header_left_d == 8'd0) begin
					phase_d = PH_TAG;
				end
			end
			PH_TAG: begin
				phase_d      = tag_phase;
				bytes_left_d = tag_bl;
				ext_d        = tag_ext;
			end
			PH_LEN: begin
				bytes_left_d = packet_byte;
				if (ext_q && packet_byte >= MinExtLength) begin
					phase_d = PH_TAG;
				end else begin
					ext_d   = 1'b0;
					phase_d = (packet_byte != 8'd0) ? PH_SKIP : PH_TAG;
				end
			end
			PH_SKIP: begin
				bytes_left_d = bytes_left_q - 8'd1;
				if (bytes_left_d == 8'd0) begin
					phase_d = PH_TAG;
				end
			end
			PH_LENM: begin
				copy_left_d = capped;
				copied_d    = 8'd0;
				if (capped == 8'd0) begin
					res.v0              = 1'b1;
					res.r0.kind         = KIND_DONE;
					res.r0.found        = 1'b1;
					done                = 1'b1;
					phase_d             = PH_DRAIN;
				end else begin
					phase_d = PH_COPY;
				end
			end
			PH_COPY: begin
				res.v0            = 1'b1;
				res.r0.kind       = KIND_DATA;
				res.r0.data_value = packet_byte;
				copied_d          = copied_q + 8'd1;
				copy_left_d       = copy_left_q - 8'd1;
				if (copy_left_d == 8'd0) begin
					res.v1                 = 1'b1;
					res.r1.kind            = KIND_DONE;
					res.r1.delivered_count = copied_d;
					res.r1.found           = 1'b1;
					done                   = 1'b1;
					phase_d                = PH_DRAIN;
				end
			end
			PH_DRAIN: begin
			end
		endcase

		if (packet_end) begin
			if (!done && phase_q != PH_DRAIN) begin
				matching = (phase_d == PH_LENM) || (phase_d == PH_COPY);
				if (res.v0) begin
					res.v1                 = 1'b1;
					res.r1.kind            = KIND_DONE;
					res.r1.delivered_count = matching ? copied_d : 8'd0;
					res.r1.found           = matching;
					res.r1.cut_short       = matching;
				end else begin
					res.v0                 = 1'b1;
					res.r0.kind            = KIND_DONE;
					res.r0.delivered_count = matching ? copied_d : 8'd0;
					res.r0.found           = matching;
					res.r0.cut_short       = matching;
				end
			end
			phase_d = PH_START;
			ext_d   = 1'b0;
		end

		if (!step) begin
			res.v0 = 1'b0;
			res.v1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			header_left_q <= 8'd0;
			bytes_left_q  <= 8'd0;
			ext_q         <= 1'b0;
			copy_left_q   <= 8'd0;
			copied_q      <= 8'd0;
		end else if (step) begin
			phase_q       <= phase_d;
			header_left_q <= header_left_d;
			bytes_left_q  <= bytes_left_d;
			ext_q         <= ext_d;
			copy_left_q   <= copy_left_d;
			copied_q      <= copied_d;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res.v1 |-> res.v0)
		else $error("second result without first");

	a_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done && !packet_end) |=> phase_q == PH_DRAIN)
		else $error("match done without drain");

	a_drain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN) |-> !res.v0)
		else $error("result while draining");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && packet_end) |=> phase_q == PH_START)
		else $error("packet end without restart");

endmodule

### sv/tte_result_fifo.sv
module tte_result_fifo
	import tte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t push,
	output logic      room2,
	output logic      out_valid,
	input  logic      out_ready,
	output res_t      out_res
);

	res_t               mem_q [ResDepth];
	logic [ResPtrW-1:0] wr_ptr_q;
	logic [ResPtrW-1:0] rd_ptr_q;
	logic [ResCntW-1:0] count_q;
	logic               pop;
	logic [ResPtrW-1:0] wr_next;

	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room2     = (count_q <= ResCntW'(ResDepth - 2));
	assign wr_next   = wr_ptr_q + ResPtrW'(1);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ResPtrW'(push.v0) + ResPtrW'(push.v1);
			rd_ptr_q <= rd_ptr_q + ResPtrW'(pop);
			count_q  <= count_q + ResCntW'(push.v0) + ResCntW'(push.v1) - ResCntW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room2)
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ResCntW'(ResDepth))
		else $error("result queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[ResPtrW-1:0])
		else $error("result queue pointers disagree with count");

endmodule

### sv/tlv_tag_extractor_core.sv
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] packet_byte, s_tlast packet_end
// m_*      | out | m_tvalid/m_tready  | m_tuser kind, m_tdata data/count/found/cut_short
// cfg_*    | in  | cfg_we             | cfg_addr register index, cfg_data value
//
// One word is accepted per cycle while the result queue has room; a word is
// registered ahead of the parser, and its results enter the queue feeding m_*.
// A word can yield two results (the last copied byte and its done result);
// the four-entry queue absorbs that: input stalls only while it holds three or more.
// Reset restarts the packet parse and loads the register defaults.
module tlv_tag_extractor_core
	import tte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] packet_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_value, [15:8] delivered_count,
	                               // [16] found, [17] cut_short, [23:18] zero
	output logic        m_tuser,   // [0] kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       room2;
	logic       step;
	res_pair_t  pair;
	res_t       head;

	assign step     = valid_s1 && room2;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_tag     <= WantedTagReset;
			cfg_q.extension_code <= ExtensionCodeReset;
			cfg_q.header_length  <= HeaderLengthReset;
			cfg_q.output_limit   <= OutputLimitReset;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_addr))
				REG_WANTED_TAG:     cfg_q.wanted_tag     <= cfg_data;
				REG_EXTENSION_CODE: cfg_q.extension_code <= cfg_data;
				REG_HEADER_LENGTH:  cfg_q.header_length  <= cfg_data;
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	tte_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.packet_byte (byte_s1),
		.packet_end  (end_s1),
		.cfg         (cfg_q),
		.res         (pair)
	);

	tte_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pair),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	assign m_tuser = head.kind;
	assign m_tdata = {6'd0, head.cut_short, head.found, head.delivered_count, head.data_value};

endmodule
